>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/trie_pkg.sv
// ----------------------------------------------------------------------------
// trie_pkg
// Types and codes shared by the prefix tree block: transfer payloads, mode
// codes, controller states and memory control bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trie_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_PREFIX = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] letter;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic status;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_MARK
    } state_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } ram_ctl_t;

endpackage

>>> rtl/core/trie_child_ram.sv
// ----------------------------------------------------------------------------
// trie_child_ram
// Child link store: one row per node holding one link per letter. A row is
// read whole; a write updates one link, and a clear zeroes a whole row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trie_child_ram #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26,
    parameter int NW            = $clog2(NODE_COUNT),
    parameter int LW            = $clog2(ALPHABET_SIZE)
) (
    input  logic                        aclk,
    input  trie_pkg::ram_ctl_t          ctl,
    input  logic [NW-1:0]               waddr,
    input  logic [LW-1:0]               wlane,
    input  logic [NW-1:0]               wdata,
    input  logic [NW-1:0]               raddr,
    output logic [ALPHABET_SIZE*NW-1:0] rdata
);

    logic [ALPHABET_SIZE*NW-1:0] mem [NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            mem[waddr] <= '0;
        end else if (ctl.wr) begin
            mem[waddr][wlane*NW +: NW] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/trie_mark_ram.sv
// ----------------------------------------------------------------------------
// trie_mark_ram
// Word end marks: one bit per node, set when an inserted word ends there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trie_mark_ram #(
    parameter int NODE_COUNT = 1024,
    parameter int NW         = $clog2(NODE_COUNT)
) (
    input  logic               aclk,
    input  trie_pkg::ram_ctl_t ctl,
    input  logic [NW-1:0]      waddr,
    input  logic [NW-1:0]      raddr,
    output logic               rdata
);

    logic mem [NODE_COUNT];

    always_ff @(posedge aclk) begin
        if (ctl.clr) begin
            mem[waddr] <= 1'b0;
        end else if (ctl.wr) begin
            mem[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/trie_insert_and_lookup.sv
// Letter without last: child row read, then cursor update.
// Last letter: a word mark read follows; the result is registered as the
// mark state is left, which waits while an earlier result is not yet taken.
// A result waits in an output register while the next letter is taken.
// After reset a clearing pass zeroes every row of both memories;
// s_ready stays low during it.
// ----------------------------------------------------------------------------
// trie_insert_and_lookup
// Prefix tree over an alphabet of letters kept in a node pool. Words are
// inserted, searched exactly, or searched as prefixes, one letter per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trie_insert_and_lookup #(
    parameter int NODE_COUNT    = 1024,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  trie_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output trie_pkg::out_item_t m_data
);

    localparam int NW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(ALPHABET_SIZE);

    trie_pkg::state_t    state_reg, state_next;
    trie_pkg::in_item_t  item_reg, item_next;
    trie_pkg::out_item_t out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    logic [NW-1:0]       cursor_reg, cursor_next;
    logic                miss_reg, miss_next;
    logic                full_reg, full_next;
    logic [NW:0]         free_reg, free_next;
    logic [NW-1:0]       clr_cnt_reg, clr_cnt_next;

    trie_pkg::ram_ctl_t          child_ctl, mark_ctl;
    logic [NW-1:0]               child_waddr, mark_waddr, mark_raddr;
    logic [ALPHABET_SIZE*NW-1:0] child_row;
    logic                        mark_q;

    logic [LW-1:0] lane;
    logic [NW-1:0] child;
    logic          in_range;
    logic          active;
    logic          out_free;

    assign lane     = LW'(item_reg.letter);
    assign in_range = 32'(item_reg.letter) < ALPHABET_SIZE;
    assign active   = !miss_reg && !full_reg && in_range;
    assign child    = child_row[lane*NW +: NW];
    assign out_free = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == trie_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= trie_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
            cursor_reg  <= '0;
            miss_reg    <= 1'b0;
            full_reg    <= 1'b0;
            free_reg    <= (NW+1)'(1);
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cursor_reg  <= cursor_next;
            miss_reg    <= miss_next;
            full_reg    <= full_next;
            free_reg    <= free_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        cursor_next  = cursor_reg;
        miss_next    = miss_reg;
        full_next    = full_reg;
        free_next    = free_reg;
        clr_cnt_next = clr_cnt_reg;
        child_ctl    = '0;
        mark_ctl     = '0;
        child_waddr  = cursor_reg;
        mark_waddr   = cursor_reg;
        mark_raddr   = cursor_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            trie_pkg::ST_CLEAR: begin
                child_ctl.clr = 1'b1;
                mark_ctl.clr  = 1'b1;
                child_waddr   = clr_cnt_reg;
                mark_waddr    = clr_cnt_reg;
                clr_cnt_next  = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == NW'(NODE_COUNT - 1)) begin
                    state_next = trie_pkg::ST_IDLE;
                end
            end
            trie_pkg::ST_IDLE: begin
                // The row of the current cursor is read as the letter is taken.
                if (s_valid) begin
                    item_next    = s_data;
                    child_ctl.rd = 1'b1;
                    state_next   = trie_pkg::ST_STEP;
                end
            end
            trie_pkg::ST_STEP: begin
                if (active) begin
                    if (child != '0) begin
                        cursor_next = child;
                    end else if (item_reg.mode == trie_pkg::MODE_INSERT) begin
                        if (free_reg < (NW+1)'(NODE_COUNT)) begin
                            child_ctl.wr = 1'b1;
                            cursor_next  = free_reg[NW-1:0];
                            free_next    = free_reg + 1'b1;
                        end else begin
                            full_next = 1'b1;
                        end
                    end else begin
                        miss_next = 1'b1;
                    end
                end
                if (item_reg.last) begin
                    mark_ctl.rd = 1'b1;
                    mark_raddr  = cursor_next;
                    state_next  = trie_pkg::ST_MARK;
                end else begin
                    state_next = trie_pkg::ST_IDLE;
                end
            end
            trie_pkg::ST_MARK: begin
                // Hold here until the output register can take the result.
                if (out_free) begin
                    out_next = '0;
                    case (item_reg.mode)
                        trie_pkg::MODE_INSERT: begin
                            out_next.status = full_reg;
                            mark_ctl.wr     = !full_reg && !miss_reg;
                        end
                        trie_pkg::MODE_SEARCH: begin
                            out_next.found = !miss_reg && !full_reg && mark_q;
                        end
                        default: begin
                            out_next.found = !miss_reg && !full_reg;
                        end
                    endcase
                    m_valid_next = 1'b1;
                    cursor_next  = '0;
                    miss_next    = 1'b0;
                    full_next    = 1'b0;
                    state_next   = trie_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = trie_pkg::ST_IDLE;
            end
        endcase
    end

    trie_child_ram #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .NW            (NW),
        .LW            (LW)
    ) u_child_ram (
        .aclk  (aclk),
        .ctl   (child_ctl),
        .waddr (child_waddr),
        .wlane (lane),
        .wdata (free_reg[NW-1:0]),
        .raddr (cursor_reg),
        .rdata (child_row)
    );

    trie_mark_ram #(
        .NODE_COUNT (NODE_COUNT),
        .NW         (NW)
    ) u_mark_ram (
        .aclk  (aclk),
        .ctl   (mark_ctl),
        .waddr (mark_waddr),
        .raddr (mark_raddr),
        .rdata (mark_q)
    );

endmodule

>>> rtl/core/trie_chk.sv
// ----------------------------------------------------------------------------
// trie_chk
// Port-level checks for the prefix tree block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trie_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input trie_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input trie_pkg::out_item_t m_data
);

    // A waiting result must hold until it is taken.
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // A full pool only occurs on insert, which never reports found.
    `CHK_ASSERT(a_full_not_found, aclk, aresetn, m_valid |-> !(m_data.found && m_data.status), "found and status both set")

    // Every letter needs a memory read before the next one can be taken.
    `CHK_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "letter accepted on consecutive cycles")

    // A new result appears only as the controller returns from work on a letter.
    `CHK_ASSERT(a_result_after_work, aclk, aresetn, $rose(m_valid) |-> $past(!s_ready), "result without preceding letter work")

endmodule

bind trie_insert_and_lookup trie_chk u_trie_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
